[hw/rtl/cdll_pkg.sv]
// Shared codes for the circular doubly linked list block: operation codes,
// result status codes and fixed field widths. No dependencies.
`timescale 1ns / 1ps

package cdll_pkg;

  localparam int OP_W     = 2;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 2'd0,
    OP_DELETE   = 2'd1,
    OP_TRAV_FWD = 2'd2,
    OP_TRAV_BWD = 2'd3
  } op_t;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_INSERTED  = 3'd0;
  localparam status_t ST_DELETED   = 3'd1;
  localparam status_t ST_NOT_FOUND = 3'd2;
  localparam status_t ST_EMPTY     = 3'd3;
  localparam status_t ST_FULL      = 3'd4;
  localparam status_t ST_ELEMENT   = 3'd5;

endpackage

[hw/rtl/cdll_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Used for the node value and link stores. No dependencies.
`timescale 1ns / 1ps

module cdll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/circular_doubly_linked_list.sv]
// Circular doubly linked list of signed 32-bit values held in a node store of
// CAPACITY entries (value, next and previous link RAMs, one read port each),
// with a used map, a head pointer and an entry count in flip-flops. One item
// is worked at a time; in_ready is high only between items. An insert reads
// the tail link, writes the value and two link pairs, then presents its
// status. A delete compares nodes from the head until a match or the end of
// the list. A traversal presents one node per cycle while out_ready is high.
// The pace of one node per cycle is set by the single registered read port
// of the node store, whose read data feeds the next read address. An empty
// list or a full store goes straight to its result. A finished result waits
// in the output register while the next item is taken.
// Depends on cdll_pkg and cdll_ram.
`timescale 1ns / 1ps

module circular_doubly_linked_list #(
  parameter int CAPACITY = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [cdll_pkg::OP_W-1:0]              op,
  input  logic signed [cdll_pkg::DATA_W-1:0]     value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [cdll_pkg::STATUS_W-1:0]          status,
  output logic signed [cdll_pkg::DATA_W-1:0]     item,
  output logic                                   last
);

  import cdll_pkg::*;

  localparam int IdxW = $clog2(CAPACITY);
  localparam int CntW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LINK1 = 5'b00010,
    S_LINK2 = 5'b00100,
    S_WALK  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t              state;
  logic [CAPACITY-1:0] node_used;
  logic [IdxW-1:0]     head_index;
  logic [CntW-1:0]     entry_count;

  op_t                 req_op;
  logic [DATA_W-1:0]   req_value;
  logic [IdxW-1:0]     ins_slot;
  logic [IdxW-1:0]     cur;
  logic [CntW-1:0]     walk_idx;
  status_t             done_status;
  status_t             out_status;
  logic [DATA_W-1:0]   out_item;
  logic                out_last;

  logic [CAPACITY-1:0] free_map;
  logic [CAPACITY-1:0] lowest_free;
  logic [IdxW-1:0]     free_slot;
  logic                is_full;
  logic                is_empty;
  logic                accept;
  logic                can_load;
  logic                out_load;
  logic                walk_last;
  logic                is_match;
  logic                is_del;
  logic                walk_go;
  logic                walk_adv;
  logic                del_unlink;
  logic [IdxW-1:0]     walk_next;
  logic [IdxW-1:0]     ins_tail;
  logic [IdxW-1:0]     ins_head;

  logic                rd_en;
  logic [IdxW-1:0]     rd_addr;
  logic [DATA_W-1:0]   val_rdata;
  logic [IdxW-1:0]     next_rdata;
  logic [IdxW-1:0]     prev_rdata;
  logic                val_we;
  logic                next_we;
  logic [IdxW-1:0]     next_waddr;
  logic [IdxW-1:0]     next_wdata;
  logic                prev_we;
  logic [IdxW-1:0]     prev_waddr;
  logic [IdxW-1:0]     prev_wdata;

  // Lowest free entry: isolate the lowest set bit of the free map, then encode.
  assign free_map    = ~node_used;
  assign lowest_free = free_map & (~free_map + 1'b1);

  always_comb begin
    free_slot = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (lowest_free[i]) begin
        free_slot = free_slot | IdxW'(i);
      end
    end
  end

  assign is_full    = (entry_count == CntW'(CAPACITY));
  assign is_empty   = (entry_count == '0);
  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign can_load   = !out_valid || out_ready;
  assign walk_last  = ((walk_idx + CntW'(1)) == entry_count);
  assign is_match   = (val_rdata == req_value);
  assign is_del     = (req_op == OP_DELETE);
  assign walk_next  = (req_op == OP_TRAV_BWD) ? prev_rdata : next_rdata;
  assign walk_go    = (state == S_WALK) && (is_del || can_load);
  assign walk_adv   = walk_go && !walk_last && !(is_del && is_match);
  assign del_unlink = walk_go && is_del && is_match;
  assign ins_tail   = is_empty ? ins_slot : prev_rdata;
  assign ins_head   = is_empty ? ins_slot : head_index;
  assign out_load   = (walk_go && !is_del) || ((state == S_DONE) && can_load);

  // Read the head on transfer; during a walk the link just read is the next address.
  assign rd_en   = (accept && !is_empty && !(op == OP_INSERT && is_full)) || walk_adv;
  assign rd_addr = (state == S_IDLE) ? head_index : walk_next;

  assign val_we = (state == S_LINK1);

  always_comb begin
    next_we    = 1'b0;
    next_waddr = ins_tail;
    next_wdata = ins_slot;
    prev_we    = 1'b0;
    prev_waddr = ins_slot;
    prev_wdata = ins_tail;
    case (state)
      S_LINK1: begin
        next_we = 1'b1;
        prev_we = 1'b1;
      end
      S_LINK2: begin
        next_we    = 1'b1;
        next_waddr = ins_slot;
        next_wdata = ins_head;
        prev_we    = 1'b1;
        prev_waddr = ins_head;
        prev_wdata = ins_slot;
      end
      S_WALK: begin
        // bridge the neighbors of the matched node
        next_we    = del_unlink;
        next_waddr = prev_rdata;
        next_wdata = next_rdata;
        prev_we    = del_unlink;
        prev_waddr = next_rdata;
        prev_wdata = prev_rdata;
      end
      default: begin
        next_we = 1'b0;
        prev_we = 1'b0;
      end
    endcase
  end

  cdll_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (ins_slot),
    .wdata (req_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (val_rdata)
  );

  cdll_ram #(.WIDTH(IdxW), .DEPTH(CAPACITY)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (next_rdata)
  );

  cdll_ram #(.WIDTH(IdxW), .DEPTH(CAPACITY)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (prev_rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      node_used   <= '0;
      head_index  <= '0;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (op == OP_INSERT) begin
              state <= is_full ? S_DONE : S_LINK1;
            end else begin
              state <= is_empty ? S_DONE : S_WALK;
            end
          end
        end
        S_LINK1: begin
          state <= S_LINK2;
        end
        S_LINK2: begin
          node_used[ins_slot] <= 1'b1;
          entry_count         <= entry_count + 1'b1;
          if (is_empty) begin
            head_index <= ins_slot;
          end
          state <= S_DONE;
        end
        S_WALK: begin
          if (walk_go) begin
            if (is_del) begin
              if (is_match) begin
                node_used[cur] <= 1'b0;
                entry_count    <= entry_count - 1'b1;
                if (entry_count == CntW'(1)) begin
                  head_index <= '0;
                end else if (cur == head_index) begin
                  head_index <= next_rdata;
                end
                state <= S_DONE;
              end else if (walk_last) begin
                state <= S_DONE;
              end
            end else begin
              if (walk_last) begin
                state <= S_IDLE;
              end
            end
          end
        end
        S_DONE: begin
          if (can_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          req_op    <= op_t'(op);
          req_value <= value;
          ins_slot  <= free_slot;
          cur       <= head_index;
          walk_idx  <= '0;
          done_status <= (op == OP_INSERT) ? ST_FULL : ST_EMPTY;
        end
      end
      S_LINK2: begin
        done_status <= ST_INSERTED;
      end
      S_WALK: begin
        if (walk_go) begin
          if (is_del) begin
            done_status <= is_match ? ST_DELETED : ST_NOT_FOUND;
          end else begin
            out_status <= ST_ELEMENT;
            out_item   <= val_rdata;
            out_last   <= walk_last;
          end
          if (walk_adv) begin
            cur      <= walk_next;
            walk_idx <= walk_idx + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (can_load) begin
          out_status <= done_status;
          out_item   <= '0;
          out_last   <= 1'b1;
        end
      end
      default: begin
        req_op <= req_op;
      end
    endcase
  end

  assign status = out_status;
  assign item   = $signed(out_item);
  assign last   = out_last;

  a_count_matches_map: assert property (@(posedge clk) disable iff (rst)
    $countones(node_used) == entry_count)
    else $error("entry count disagrees with used map");

  a_head_in_use: assert property (@(posedge clk) disable iff (rst)
    !is_empty |-> node_used[head_index])
    else $error("head points at a free entry");

  a_walk_on_used: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> node_used[cur])
    else $error("walk reached a free entry");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    state == S_LINK2 |=> entry_count == $past(entry_count) + 1'b1)
    else $error("insert did not grow the list by one");

endmodule
